/* rtl/core/lvs_pkg.sv */
`default_nettype none
package lvs_pkg;
	localparam int unsigned MAX_WIDTH_DEF  = 4096;
	localparam int unsigned MAX_HEIGHT_DEF = 4096;
	localparam int unsigned FRAC_BITS_DEF  = 8;
	localparam int unsigned VAR_W = 28;
	localparam int unsigned CNT_W = 25;
	localparam int unsigned SUM_W = 35;
	localparam int unsigned SQ_W  = 45;
	localparam int unsigned DIM_W = 13;
	localparam int unsigned POS_W = 12;
	localparam int unsigned LAP_W = 11;
	localparam int unsigned NUM_W = 128;

	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_ROI_LEFT     = 3'd2;
	localparam logic [2:0] REG_ROI_TOP      = 3'd3;
	localparam logic [2:0] REG_ROI_WIDTH    = 3'd4;
	localparam logic [2:0] REG_ROI_HEIGHT   = 3'd5;

	typedef enum logic [2:0] {
		ST_RUN, ST_PIX, ST_MUL, ST_SUB, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic take_pixel;
		logic step_pixel;
		logic start_math;
		logic mul_step;
		logic sub_step;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic mul_last;
		logic div_last;
	} sts_t;
endpackage
`default_nettype wire

/* rtl/core/laplacian_variance_sharpness.sv */
`default_nettype none
// Variance-of-Laplacian focus measure. While a frame streams in, a read step
// fetches the two line memories, then an update step writes the window, the
// line memories and the sums; no new pixel is taken before that update. After
// the last pixel of a frame the input stays stalled through the pixel update,
// seven 25x18 multiply steps, one subtract, a 128-step restoring divider
// computing (n*sumsq - sum^2) << FRAC_BITS / n^2, and the load of the result
// word, and longer while an earlier result word still waits at the output.
// Line storage is two MAX_WIDTH x 8 line memories.
module laplacian_variance_sharpness
	import lvs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire  [2:0]       cfg_index,
	input  wire  [DIM_W-1:0] cfg_data,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire  [7:0]       pixel,
	input  wire              start_of_frame,
	output logic             out_valid,
	input  wire              out_stall,
	output logic [VAR_W-1:0] variance_q8,
	output logic [CNT_W-1:0] sample_count,
	output logic [SUM_W-1:0] laplacian_sum
);
	logic [DIM_W-1:0] fw_q, fh_q, rw_q, rh_q;
	logic [POS_W-1:0] rl_q, rt_q;
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= DIM_W'(4096); fh_q <= DIM_W'(4096);
			rl_q <= '0; rt_q <= '0;
			rw_q <= DIM_W'(4096); rh_q <= DIM_W'(4096);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data;
				REG_FRAME_HEIGHT: fh_q <= cfg_data;
				REG_ROI_LEFT:     rl_q <= cfg_data[POS_W-1:0];
				REG_ROI_TOP:      rt_q <= cfg_data[POS_W-1:0];
				REG_ROI_WIDTH:    rw_q <= cfg_data;
				REG_ROI_HEIGHT:   rh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	lvs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	lvs_datapath #(
		.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pixel(pixel), .start_of_frame(start_of_frame),
		.frame_width(fw_q), .frame_height(fh_q), .roi_left(rl_q), .roi_top(rt_q),
		.roi_width(rw_q), .roi_height(rh_q),
		.variance_q8(variance_q8), .sample_count(sample_count),
		.laplacian_sum(laplacian_sum)
	);
endmodule
`default_nettype wire

/* rtl/core/lvs_ctrl.sv */
`default_nettype none
module lvs_ctrl
	import lvs_pkg::*;
(
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire  out_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_n;
	logic   valid_q;

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_RUN: if (in_valid) state_n = ST_PIX;
			ST_PIX: state_n = sts.frame_end ? ST_MUL : ST_RUN;
			ST_MUL: if (sts.mul_last) state_n = ST_SUB;
			ST_SUB: state_n = ST_DIV;
			ST_DIV: if (sts.div_last) state_n = ST_OUT;
			ST_OUT: if (!valid_q || !out_stall) state_n = ST_RUN;
			default: state_n = ST_RUN;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_RUN: begin
				in_stall = 1'b0;
				cmd.take_pixel = in_valid;
			end
			ST_PIX: begin
				cmd.step_pixel = 1'b1;
				cmd.start_math = sts.frame_end;
			end
			ST_MUL: cmd.mul_step = 1'b1;
			ST_SUB: cmd.sub_step = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_OUT: cmd.out_load = !valid_q || !out_stall;
			default: ;
		endcase
	end

	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) valid_q <= 1'b1;
			else if (!out_stall) valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/lvs_datapath.sv */
`default_nettype none
module lvs_datapath
	import lvs_pkg::*;
#(
	parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  wire  [7:0]        pixel,
	input  wire               start_of_frame,
	input  wire  [DIM_W-1:0]  frame_width,
	input  wire  [DIM_W-1:0]  frame_height,
	input  wire  [POS_W-1:0]  roi_left,
	input  wire  [POS_W-1:0]  roi_top,
	input  wire  [DIM_W-1:0]  roi_width,
	input  wire  [DIM_W-1:0]  roi_height,
	output logic [VAR_W-1:0]  variance_q8,
	output logic [CNT_W-1:0]  sample_count,
	output logic [SUM_W-1:0]  laplacian_sum
);
	localparam int unsigned AW = $clog2(MAX_WIDTH);
	localparam int unsigned CW = AW + 1;
	localparam int unsigned RW = $clog2(MAX_HEIGHT) + 1;
	localparam int unsigned PW = 16;
	localparam logic [PW-1:0] MAXW = PW'(MAX_WIDTH);
	localparam logic [PW-1:0] MAXH = PW'(MAX_HEIGHT);
	localparam logic [2:0] MUL_LAST = 3'd6;

	logic [7:0] mid_mem [MAX_WIDTH];
	logic [7:0] top_mem [MAX_WIDTH];

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [7:0]    w0_q, w1_q, w2_q, w4_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]  sq_q;
	logic [CNT_W-1:0] cnt_q;
	logic [7:0]    mid_s1, top_s1, pix_s1;
	logic          sof_s1;

	logic [CW-1:0] c;
	logic [RW-1:0] r;
	logic [AW-1:0] ci, ci_rd;
	logic [PW-1:0] w_eff, h_eff, cx, ry, x0, y0, x1, y1, xe, ye;
	logic [7:0]    old_mid, old_top;
	logic          hit, col_end, row_end;
	logic signed [LAP_W-1:0] lap;
	logic [LAP_W-1:0] mag;

	assign ci_rd = start_of_frame ? '0 : col_q[AW-1:0];
	assign c  = sof_s1 ? '0 : col_q;
	assign r  = sof_s1 ? '0 : row_q;
	assign ci = c[AW-1:0];
	assign old_mid = mid_s1;
	assign old_top = top_s1;

	always_comb begin
		w_eff = (frame_width == '0) ? PW'(1) :
			((PW'(frame_width) > MAXW) ? MAXW : PW'(frame_width));
		h_eff = (frame_height == '0) ? PW'(1) :
			((PW'(frame_height) > MAXH) ? MAXH : PW'(frame_height));
		cx = PW'(c);
		ry = PW'(r);
		x0 = (roi_left > POS_W'(1)) ? PW'(roi_left) : PW'(1);
		y0 = (roi_top > POS_W'(1)) ? PW'(roi_top) : PW'(1);
		xe = PW'(roi_left) + PW'(roi_width);
		ye = PW'(roi_top) + PW'(roi_height);
		x1 = (xe > w_eff - PW'(1)) ? w_eff - PW'(1) : xe;
		y1 = (ye > h_eff - PW'(1)) ? h_eff - PW'(1) : ye;
		hit = (cx >= PW'(2)) && (ry >= PW'(2)) && (cx >= x0 + PW'(1)) && (cx <= x1)
			&& (ry >= y0 + PW'(1)) && (ry <= y1);
		lap = LAP_W'(w0_q) + LAP_W'(old_mid) + LAP_W'(w2_q) + LAP_W'(w4_q)
			- {1'b0, w1_q, 2'b00};
		mag = lap[LAP_W-1] ? LAP_W'(-lap) : LAP_W'(lap);
		col_end = cx >= w_eff - PW'(1);
		row_end = ry >= h_eff - PW'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.take_pixel) begin
			mid_s1 <= mid_mem[ci_rd];
			top_s1 <= top_mem[ci_rd];
			pix_s1 <= pixel;
			sof_s1 <= start_of_frame;
		end
		if (cmd.step_pixel) begin
			top_mem[ci] <= old_mid;
			mid_mem[ci] <= pix_s1;
		end
	end

	// math registers
	logic [CNT_W-1:0] n_q;
	logic signed [SUM_W-1:0] s_q;
	logic [SQ_W-1:0]  s2_q;
	logic [SUM_W-1:0] smag;
	logic [2*SUM_W-1:0] a_q, b_q;
	logic [2*CNT_W-1:0] d_q;
	logic [NUM_W-1:0]   num_q;
	logic [2*CNT_W:0]   rem_q;
	logic [NUM_W-1:0]   quo_q;
	logic [7:0]         it_q;
	logic [2:0]         mk_q;
	logic [CNT_W-1:0]   mx;
	logic [17:0]        my;
	logic [CNT_W+17:0]  prod;
	logic [2*SUM_W-1:0] pp;
	logic [2*CNT_W:0]   rem_sh;
	logic [2*CNT_W+1:0] rem_tr;

	assign smag = s_q[SUM_W-1] ? SUM_W'(-s_q) : SUM_W'(s_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0;
			w0_q <= '0; w1_q <= '0; w2_q <= '0; w4_q <= '0;
			sum_q <= '0; sq_q <= '0; cnt_q <= '0;
		end else if (cmd.step_pixel) begin
			w0_q <= w1_q; w1_q <= old_mid; w2_q <= old_top; w4_q <= pix_s1;
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : r + RW'(1);
			end else begin
				col_q <= c + CW'(1);
				row_q <= r;
			end
			if (col_end && row_end) begin
				sum_q <= '0; sq_q <= '0; cnt_q <= '0;
			end else begin
				sum_q <= (sof_s1 ? '0 : sum_q) + (hit ? SUM_W'(lap) : '0);
				sq_q  <= (sof_s1 ? '0 : sq_q) + (hit ? SQ_W'(mag) * SQ_W'(mag) : '0);
				cnt_q <= (sof_s1 ? '0 : cnt_q) + (hit ? CNT_W'(1) : '0);
			end
		end
	end

	// n * sumsq in three slices of sumsq, then sum^2 as four partial products of its low 18 and high 17 bits
	always_comb begin
		mx = n_q;
		my = s2_q[17:0];
		case (mk_q)
			3'd0: begin mx = n_q; my = s2_q[17:0]; end
			3'd1: begin mx = n_q; my = s2_q[35:18]; end
			3'd2: begin mx = n_q; my = {9'b0, s2_q[44:36]}; end
			3'd3: begin mx = CNT_W'(smag[17:0]); my = smag[17:0]; end
			3'd4: begin mx = CNT_W'(smag[17:0]); my = {1'b0, smag[34:18]}; end
			3'd5: begin mx = CNT_W'(smag[34:18]); my = smag[17:0]; end
			3'd6: begin mx = CNT_W'(smag[34:18]); my = {1'b0, smag[34:18]}; end
			default: ;
		endcase
		prod = (CNT_W+18)'(mx) * (CNT_W+18)'(my);
		case (mk_q)
			3'd0, 3'd3: pp = (2*SUM_W)'(prod);
			3'd1, 3'd4, 3'd5: pp = (2*SUM_W)'(prod) << 18;
			default: pp = (2*SUM_W)'(prod) << 36;
		endcase
	end

	assign rem_sh = {rem_q[2*CNT_W-1:0], num_q[NUM_W-1]};
	assign rem_tr = {1'b0, rem_sh} - {2'b00, d_q};
	assign sts = '{frame_end: col_end && row_end, mul_last: mk_q == MUL_LAST,
		div_last: it_q == 8'(NUM_W - 1)};

	always_ff @(posedge clk) begin
		if (cmd.start_math) begin
			n_q  <= cnt_q + (hit ? CNT_W'(1) : '0);
			s_q  <= sof_s1 ? SUM_W'(hit ? SUM_W'(lap) : '0)
				: sum_q + (hit ? SUM_W'(lap) : '0);
			s2_q <= (sof_s1 ? '0 : sq_q) + (hit ? SQ_W'(mag) * SQ_W'(mag) : '0);
			if (sof_s1) n_q <= hit ? CNT_W'(1) : '0;
			a_q  <= '0;
			b_q  <= '0;
			mk_q <= '0;
		end
		if (cmd.mul_step) begin
			mk_q <= mk_q + 3'd1;
			if (mk_q <= 3'd2) a_q <= a_q + pp;
			else b_q <= b_q + pp;
		end
		if (cmd.sub_step) begin
			num_q <= (a_q >= b_q) ? NUM_W'(a_q - b_q) << FRAC_BITS : '0;
			d_q   <= (2*CNT_W)'(n_q) * (2*CNT_W)'(n_q);
			rem_q <= '0;
			quo_q <= '0;
			it_q  <= '0;
		end
		if (cmd.div_step) begin
			num_q <= num_q << 1;
			it_q  <= it_q + 8'd1;
			if (!rem_tr[2*CNT_W+1]) begin
				rem_q <= rem_tr[2*CNT_W:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			if (n_q == '0) variance_q8 <= '0;
			else if (quo_q > NUM_W'({VAR_W{1'b1}})) variance_q8 <= '1;
			else variance_q8 <= quo_q[VAR_W-1:0];
			sample_count  <= n_q;
			laplacian_sum <= s_q;
		end
	end
endmodule
`default_nettype wire
